// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the line editor datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define TLE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define TLE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

// ----- rtl/core/tle_pkg.sv -----
// Shared constants, codes and command/status types of the line editor.
package tle_pkg;

  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 3;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Bit positions inside the mode register.
  localparam int MODE_ISIG  = 0;
  localparam int MODE_CANON = 1;
  localparam int MODE_ECHO  = 2;

  localparam logic [MODE_W-1:0] MODE_RESET  = 3'd7;
  localparam logic [BYTE_W-1:0] INTR_RESET  = 8'd3;
  localparam logic [BYTE_W-1:0] ERASE_RESET = 8'd8;
  localparam logic [BYTE_W-1:0] KILL_RESET  = 8'd21;

  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_CARET = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_C     = 8'h43;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 3'd0,
    CFG_INTR  = 3'd1,
    CFG_ERASE = 3'd2,
    CFG_KILL  = 3'd3,
    CFG_FG    = 3'd4
  } tle_cfg_reg_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO  = 3'd0,
    KIND_DATA  = 3'd1,
    KIND_SIG   = 3'd2,
    KIND_WAKE  = 3'd3,
    KIND_EMPTY = 3'd4
  } tle_kind_e;

  // Class of a received byte, in priority order.
  typedef enum logic [2:0] {
    CLS_INTR  = 3'd0,
    CLS_ERASE = 3'd1,
    CLS_KILL  = 3'd2,
    CLS_EOL   = 3'd3,
    CLS_OTHER = 3'd4
  } tle_cls_e;

  // Source of the byte in an emitted result.
  typedef enum logic [2:0] {
    BSEL_ZERO  = 3'd0,
    BSEL_IN    = 3'd1,
    BSEL_RD    = 3'd2,
    BSEL_LF    = 3'd3,
    BSEL_BS    = 3'd4,
    BSEL_SP    = 3'd5,
    BSEL_CARET = 3'd6,
    BSEL_C     = 3'd7
  } tle_bsel_e;

  typedef struct packed {
    logic      item_load;
    logic      rd_en;
    logic      rd_prev;
    logic      push;
    logic      push_lf;
    logic      pop;
    logic      dec_wr;
    logic      emit;
    tle_kind_e kind;
    tle_bsel_e bsel;
    logic      eol;
    logic      last;
  } tle_cmd_t;

  typedef struct packed {
    logic     is_read;
    tle_cls_e cls;
    logic     empty;
    logic     full;
    logic     rd_is_lf;
    logic     rd_is_intr;
    logic     echo;
    logic     canon;
    logic     fg;
    logic     emit_ok;
  } tle_sts_t;

endpackage

// ----- rtl/core/tle_if.sv -----
// Valid/ready channel interfaces for input items, results and configuration writes.
interface tle_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [tle_pkg::BYTE_W-1:0]  in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface tle_out_if;
  logic                        valid;
  logic                        ready;
  logic [tle_pkg::KIND_W-1:0]  kind;
  logic [tle_pkg::BYTE_W-1:0]  out_byte;
  logic                        end_of_line;
  logic                        last;

  modport source (output valid, output kind, output out_byte, output end_of_line,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input end_of_line,
                  input last, output ready);
endinterface

interface tle_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tle_pkg::CFG_IDX_W-1:0]   index;
  logic [tle_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/tty_canonical_line_editor.sv -----
// Canonical-mode terminal line editor over a byte ring: the top level.
//
// This block is a terminal line discipline. Each input word is either a
// received byte (action 0) or a request from the reader for one byte
// (action 1); each produces zero or more result words, the final one marked
// by last. Received bytes are stored in a ring of RING_DEPTH entries that
// holds at most RING_DEPTH - 1 bytes. In canonical mode the erase byte
// removes the newest byte of the current line and echoes backspace, space,
// backspace; the kill byte removes the whole current line with one
// backspace echo per byte; CR and LF store a newline and wake the reader.
// The interrupt byte is stored when there is room, raises a signal when a
// foreground group is present, and always wakes the reader. A read returns
// the oldest byte; a stored interrupt byte is returned as a newline after a
// "^C" echo when echo is on. One word is handled at a time: the accepting
// state is followed by a decode state and then by the states that give the
// result words, each waiting while the output register cannot take its
// word. A read of an empty ring is answered from the decode state; any
// other read first passes a state for the registered ring read, and a
// stored interrupt byte read with echo on adds its "^C" and newline echoes.
// The ring has a single registered read port, so each byte that kill or
// erase inspects costs a read state: kill passes a test and a check state
// per removed byte, and erase a check state before its echoes. Results
// leave through an output register, so a stalled sink holds the controller
// only when a new result is ready. Configuration writes are always accepted
// and should be issued only while no word is in progress; the ring contents
// need no clearing after reset.
module tty_canonical_line_editor (
  input  logic      clk_i,
  input  logic      rst_ni,
  tle_in_if.sink    in_i,
  tle_out_if.source out_o,
  tle_cfg_if.sink   cfg_i
);

  tle_pkg::tle_cmd_t cmd;
  tle_pkg::tle_sts_t sts;

  // Configuration registers take every write at once.
  assign cfg_i.ready = 1'b1;

  tle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tle_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_action_i (in_i.action),
    .in_byte_i   (in_i.in_byte),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_kind_o  (out_o.kind),
    .out_byte_o  (out_o.out_byte),
    .out_eol_o   (out_o.end_of_line),
    .out_last_o  (out_o.last)
  );

endmodule

// ----- rtl/core/tle_dp.sv -----
// Datapath: configuration registers, byte ring with indices, and result register.
`include "assert_macros.svh"

module tle_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_action_i,
  input  logic [tle_pkg::BYTE_W-1:0]     in_byte_i,
  input  logic                           cfg_valid_i,
  input  logic [tle_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tle_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  tle_pkg::tle_cmd_t              cmd_i,
  output tle_pkg::tle_sts_t              sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tle_pkg::KIND_W-1:0]     out_kind_o,
  output logic [tle_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                           out_eol_o,
  output logic                           out_last_o
);

  localparam int IW = tle_pkg::IDX_W;

  function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i);
    idx_next = (i == IW'(tle_pkg::RING_DEPTH - 1)) ? '0 : i + IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i);
    idx_prev = (i == '0) ? IW'(tle_pkg::RING_DEPTH - 1) : i - IW'(1);
  endfunction

  logic [tle_pkg::MODE_W-1:0] mode_q;
  logic [tle_pkg::BYTE_W-1:0] intr_q, erase_q, kill_q;
  logic                       fg_q;

  logic                       action_q;
  logic [tle_pkg::BYTE_W-1:0] byte_q;

  logic [IW-1:0]              wr_q, rd_q;
  logic [tle_pkg::BYTE_W-1:0] mem [tle_pkg::RING_DEPTH];
  logic [tle_pkg::BYTE_W-1:0] rdata_q;

  logic                       out_valid_q;
  tle_pkg::tle_kind_e         out_kind_q;
  logic [tle_pkg::BYTE_W-1:0] out_byte_q;
  logic                       out_eol_q, out_last_q;

  logic [IW-1:0]              wr_prev;
  logic                       empty, full, emit_ok;
  logic                       isig, canon, echo;
  tle_pkg::tle_cls_e          cls;
  logic [tle_pkg::BYTE_W-1:0] emit_byte;

  assign wr_prev = idx_prev(wr_q);
  assign empty   = (wr_q == rd_q);
  assign full    = (idx_next(wr_q) == rd_q);
  assign emit_ok = !out_valid_q || out_ready_i;
  assign isig    = mode_q[tle_pkg::MODE_ISIG];
  assign canon   = mode_q[tle_pkg::MODE_CANON];
  assign echo    = mode_q[tle_pkg::MODE_ECHO];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tle_pkg::MODE_RESET;
      intr_q  <= tle_pkg::INTR_RESET;
      erase_q <= tle_pkg::ERASE_RESET;
      kill_q  <= tle_pkg::KILL_RESET;
      fg_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tle_pkg::CFG_MODE:  mode_q  <= cfg_data_i[tle_pkg::MODE_W-1:0];
        tle_pkg::CFG_INTR:  intr_q  <= cfg_data_i;
        tle_pkg::CFG_ERASE: erase_q <= cfg_data_i;
        tle_pkg::CFG_KILL:  kill_q  <= cfg_data_i;
        tle_pkg::CFG_FG:    fg_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      action_q <= in_action_i;
      byte_q   <= in_byte_i;
    end
  end

  // Byte classification, highest priority first.
  always_comb begin
    if (isig && byte_q == intr_q) begin
      cls = tle_pkg::CLS_INTR;
    end else if (canon && (byte_q == erase_q || byte_q == tle_pkg::CH_BS)) begin
      cls = tle_pkg::CLS_ERASE;
    end else if (canon && byte_q == kill_q) begin
      cls = tle_pkg::CLS_KILL;
    end else if (canon && (byte_q == tle_pkg::CH_LF || byte_q == tle_pkg::CH_CR)) begin
      cls = tle_pkg::CLS_EOL;
    end else begin
      cls = tle_pkg::CLS_OTHER;
    end
  end

  // Ring storage with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_q] <= cmd_i.push_lf ? tle_pkg::CH_LF : byte_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[cmd_i.rd_prev ? wr_prev : rd_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (cmd_i.push) begin
        wr_q <= idx_next(wr_q);
      end else if (cmd_i.dec_wr) begin
        wr_q <= wr_prev;
      end
      if (cmd_i.pop) begin
        rd_q <= idx_next(rd_q);
      end
    end
  end

  always_comb begin
    case (cmd_i.bsel)
      tle_pkg::BSEL_IN:    emit_byte = byte_q;
      tle_pkg::BSEL_RD:    emit_byte = rdata_q;
      tle_pkg::BSEL_LF:    emit_byte = tle_pkg::CH_LF;
      tle_pkg::BSEL_BS:    emit_byte = tle_pkg::CH_BS;
      tle_pkg::BSEL_SP:    emit_byte = tle_pkg::CH_SP;
      tle_pkg::BSEL_CARET: emit_byte = tle_pkg::CH_CARET;
      tle_pkg::BSEL_C:     emit_byte = tle_pkg::CH_C;
      default:             emit_byte = '0;
    endcase
  end

  // Result register: it takes a new word while the previous one leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.kind;
      out_byte_q <= emit_byte;
      out_eol_q  <= cmd_i.eol;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign out_eol_o   = out_eol_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    sts_o.is_read    = action_q;
    sts_o.cls        = cls;
    sts_o.empty      = empty;
    sts_o.full       = full;
    sts_o.rd_is_lf   = (rdata_q == tle_pkg::CH_LF);
    sts_o.rd_is_intr = (rdata_q == intr_q);
    sts_o.echo       = echo;
    sts_o.canon      = canon;
    sts_o.fg         = fg_q;
    sts_o.emit_ok    = emit_ok;
  end

  `TLE_ASSERT_NEVER(a_emit_overwrite, clk_i, rst_ni, cmd_i.emit && !emit_ok, "result overwritten")
  `TLE_ASSERT_NEVER(a_push_full, clk_i, rst_ni, cmd_i.push && full, "push into full ring")
  `TLE_ASSERT_NEVER(a_dec_empty, clk_i, rst_ni, cmd_i.dec_wr && empty, "erase from empty ring")
  `TLE_ASSERT(a_idx_range, clk_i, rst_ni, (wr_q <= IW'(tle_pkg::RING_DEPTH - 1)) && (rd_q <= IW'(tle_pkg::RING_DEPTH - 1)), "ring index out of range")

endmodule

// ----- rtl/core/tle_ctrl.sv -----
// Controller: sequences one item at a time through the datapath.
module tle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tle_pkg::tle_sts_t sts_i,
  output tle_pkg::tle_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_RD, S_R_CARET, S_R_C, S_R_DATA, S_R_LFECHO,
    S_ER_CHK, S_ER_BS1, S_ER_SP, S_ER_BS2,
    S_KL_TEST, S_KL_CHK, S_KL_END, S_SIG, S_WAKE, S_ECHO
  } state_e;

  state_e state_q, state_d;
  logic   cvt_q, cvt_d;    // read data turned into a newline
  logic   pend_q, pend_d;  // kill has removed a byte whose backspace is not yet sent
  logic   data_lf;

  assign data_lf = cvt_q || sts_i.rd_is_lf;

  always_comb begin
    state_d    = state_q;
    cvt_d      = cvt_q;
    pend_d     = pend_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          cvt_d   = 1'b0;
          pend_d  = 1'b0;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.is_read) begin
          if (sts_i.empty) begin
            if (sts_i.emit_ok) begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = tle_pkg::KIND_EMPTY;
              cmd_o.last = 1'b1;
              state_d    = S_IDLE;
            end
          end else begin
            cmd_o.rd_en = 1'b1;
            cmd_o.pop   = 1'b1;
            state_d     = S_RD;
          end
        end else begin
          case (sts_i.cls)
            tle_pkg::CLS_INTR: begin
              cmd_o.push = !sts_i.full;
              state_d    = sts_i.fg ? S_SIG : S_WAKE;
            end
            tle_pkg::CLS_ERASE: begin
              if (sts_i.empty) begin
                state_d = S_IDLE;
              end else begin
                cmd_o.rd_en   = 1'b1;
                cmd_o.rd_prev = 1'b1;
                state_d       = S_ER_CHK;
              end
            end
            tle_pkg::CLS_KILL: begin
              state_d = S_KL_TEST;
            end
            tle_pkg::CLS_EOL: begin
              cmd_o.push    = !sts_i.full;
              cmd_o.push_lf = 1'b1;
              state_d       = S_WAKE;
            end
            default: begin
              if (sts_i.full) begin
                state_d = S_IDLE;
              end else begin
                cmd_o.push = 1'b1;
                if (sts_i.echo) begin
                  state_d = S_ECHO;
                end else if (!sts_i.canon) begin
                  state_d = S_WAKE;
                end else begin
                  state_d = S_IDLE;
                end
              end
            end
          endcase
        end
      end
      S_RD: begin
        state_d = (sts_i.rd_is_intr && sts_i.echo) ? S_R_CARET : S_R_DATA;
      end
      S_R_CARET: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = tle_pkg::KIND_ECHO;
          cmd_o.bsel = tle_pkg::BSEL_CARET;
          state_d    = S_R_C;
        end
      end
      S_R_C: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = tle_pkg::KIND_ECHO;
          cmd_o.bsel = tle_pkg::BSEL_C;
          cvt_d      = 1'b1;
          state_d    = S_R_DATA;
        end
      end
      S_R_DATA: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = tle_pkg::KIND_DATA;
          cmd_o.bsel = cvt_q ? tle_pkg::BSEL_LF : tle_pkg::BSEL_RD;
          cmd_o.eol  = data_lf;
          cmd_o.last = !(data_lf && sts_i.echo);
          state_d    = (data_lf && sts_i.echo) ? S_R_LFECHO : S_IDLE;
        end
      end
      S_R_LFECHO: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = tle_pkg::KIND_ECHO;
          cmd_o.bsel = tle_pkg::BSEL_LF;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_ER_CHK: begin
        if (sts_i.rd_is_lf) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.dec_wr = 1'b1;
          state_d      = sts_i.echo ? S_ER_BS1 : S_IDLE;
        end
      end
      S_ER_BS1: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = tle_pkg::KIND_ECHO;
          cmd_o.bsel = tle_pkg::BSEL_BS;
          state_d    = S_ER_SP;
        end
      end
      S_ER_SP: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = tle_pkg::KIND_ECHO;
          cmd_o.bsel = tle_pkg::BSEL_SP;
          state_d    = S_ER_BS2;
        end
      end
      S_ER_BS2: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = tle_pkg::KIND_ECHO;
          cmd_o.bsel = tle_pkg::BSEL_BS;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_KL_TEST: begin
        if (sts_i.empty) begin
          state_d = S_KL_END;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_prev = 1'b1;
          state_d       = S_KL_CHK;
        end
      end
      S_KL_CHK: begin
        // The backspace of the previous removal goes out only now, once it is
        // known that another byte follows it.
        if (sts_i.rd_is_lf) begin
          state_d = S_KL_END;
        end else if (pend_q && sts_i.echo) begin
          if (sts_i.emit_ok) begin
            cmd_o.emit   = 1'b1;
            cmd_o.kind   = tle_pkg::KIND_ECHO;
            cmd_o.bsel   = tle_pkg::BSEL_BS;
            cmd_o.dec_wr = 1'b1;
            pend_d       = 1'b1;
            state_d      = S_KL_TEST;
          end
        end else begin
          cmd_o.dec_wr = 1'b1;
          pend_d       = 1'b1;
          state_d      = S_KL_TEST;
        end
      end
      S_KL_END: begin
        if (pend_q && sts_i.echo) begin
          if (sts_i.emit_ok) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = tle_pkg::KIND_ECHO;
            cmd_o.bsel = tle_pkg::BSEL_BS;
            cmd_o.last = 1'b1;
            state_d    = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SIG: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = tle_pkg::KIND_SIG;
          state_d    = S_WAKE;
        end
      end
      S_WAKE: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = tle_pkg::KIND_WAKE;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_ECHO: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = tle_pkg::KIND_ECHO;
          cmd_o.bsel = tle_pkg::BSEL_IN;
          cmd_o.last = sts_i.canon;
          state_d    = sts_i.canon ? S_IDLE : S_WAKE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cvt_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cvt_q   <= cvt_d;
      pend_q  <= pend_d;
    end
  end

endmodule

// ----- sim/tty_canonical_line_editor_tb.sv -----
// Self-checking testbench for the canonical-mode terminal line editor.
`timescale 1ns / 1ps

module tty_canonical_line_editor_tb;

  // Action codes of an input word.
  localparam logic ACT_RX   = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // A word that erases or kills may keep the block busy without producing any
  // result: kill walks back through up to RING_DEPTH - 1 bytes. Wait this
  // long after the last expected result before a configuration write or the
  // end of the run.
  localparam int SETTLE_CYCLES = 2 * tle_pkg::RING_DEPTH + 32;

  // One result word as the block should produce it.
  typedef struct {
    tle_pkg::tle_kind_e               kind;
    logic [tle_pkg::BYTE_W-1:0]       data;
    logic                             eol;
    logic                             last;
  } editor_word_t;

  // The scoreboard holds its own copy of the ring and the registers. Each
  // accepted input word is run through the line discipline here and the
  // result words it must cause are queued in order; each result word that
  // the block hands out is compared with the oldest queued one.
  class line_editor_scoreboard;
    logic [tle_pkg::BYTE_W-1:0] ring [tle_pkg::RING_DEPTH];
    logic [tle_pkg::IDX_W-1:0]  wr_idx;
    logic [tle_pkg::IDX_W-1:0]  rd_idx;
    logic [tle_pkg::MODE_W-1:0] mode;
    logic [tle_pkg::BYTE_W-1:0] intr_ch;
    logic [tle_pkg::BYTE_W-1:0] erase_ch;
    logic [tle_pkg::BYTE_W-1:0] kill_ch;
    logic                       fg;
    editor_word_t               pending [$];
    int                         errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_idx   = '0;
      rd_idx   = '0;
      mode     = tle_pkg::MODE_RESET;
      intr_ch  = tle_pkg::INTR_RESET;
      erase_ch = tle_pkg::ERASE_RESET;
      kill_ch  = tle_pkg::KILL_RESET;
      fg       = 1'b0;
      errors   = 0;
    endfunction

    function logic [tle_pkg::IDX_W-1:0] step_up(logic [tle_pkg::IDX_W-1:0] i);
      return tle_pkg::IDX_W'((int'(i) + 1) % tle_pkg::RING_DEPTH);
    endfunction

    function logic [tle_pkg::IDX_W-1:0] step_down(logic [tle_pkg::IDX_W-1:0] i);
      return tle_pkg::IDX_W'((int'(i) + tle_pkg::RING_DEPTH - 1) % tle_pkg::RING_DEPTH);
    endfunction

    function bit ring_empty();
      return wr_idx == rd_idx;
    endfunction

    // One slot always stays free, so the ring holds RING_DEPTH - 1 bytes.
    function bit ring_full();
      return step_up(wr_idx) == rd_idx;
    endfunction

    function void store(logic [tle_pkg::BYTE_W-1:0] b);
      if (!ring_full()) begin
        ring[wr_idx] = b;
        wr_idx = step_up(wr_idx);
      end
    endfunction

    function void add(tle_pkg::tle_kind_e kind, logic [tle_pkg::BYTE_W-1:0] data,
                      logic eol);
      editor_word_t w;
      w.kind = kind;
      w.data = data;
      w.eol  = eol;
      w.last = 1'b0;
      pending.push_back(w);
    endfunction

    function void set_reg(tle_pkg::tle_cfg_reg_e idx,
                          logic [tle_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        tle_pkg::CFG_MODE:  mode     = val[tle_pkg::MODE_W-1:0];
        tle_pkg::CFG_INTR:  intr_ch  = val;
        tle_pkg::CFG_ERASE: erase_ch = val;
        tle_pkg::CFG_KILL:  kill_ch  = val;
        tle_pkg::CFG_FG:    fg       = val[0];
        default: ;
      endcase
    endfunction

    function void note_input(logic act, logic [tle_pkg::BYTE_W-1:0] b);
      logic [tle_pkg::BYTE_W-1:0] c;
      logic sig_on;
      logic canon;
      logic echo;
      int   n_prior;
      sig_on  = mode[tle_pkg::MODE_ISIG];
      canon   = mode[tle_pkg::MODE_CANON];
      echo    = mode[tle_pkg::MODE_ECHO];
      n_prior = pending.size();
      c       = b;
      if (act == ACT_READ) begin
        if (ring_empty()) begin
          add(tle_pkg::KIND_EMPTY, '0, 1'b0);
        end else begin
          c = ring[rd_idx];
          rd_idx = step_up(rd_idx);
          // A stored interrupt byte comes back as a newline after a ^C echo.
          if (c == intr_ch && echo) begin
            add(tle_pkg::KIND_ECHO, tle_pkg::CH_CARET, 1'b0);
            add(tle_pkg::KIND_ECHO, tle_pkg::CH_C, 1'b0);
            c = tle_pkg::CH_LF;
          end
          add(tle_pkg::KIND_DATA, c, c == tle_pkg::CH_LF);
          if (c == tle_pkg::CH_LF && echo) add(tle_pkg::KIND_ECHO, tle_pkg::CH_LF, 1'b0);
        end
      end else if (sig_on && c == intr_ch) begin
        store(c);
        if (fg) add(tle_pkg::KIND_SIG, '0, 1'b0);
        add(tle_pkg::KIND_WAKE, '0, 1'b0);
      end else if (canon && (c == erase_ch || c == tle_pkg::CH_BS)) begin
        if (!ring_empty() && ring[step_down(wr_idx)] != tle_pkg::CH_LF) begin
          wr_idx = step_down(wr_idx);
          if (echo) begin
            add(tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 1'b0);
            add(tle_pkg::KIND_ECHO, tle_pkg::CH_SP, 1'b0);
            add(tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 1'b0);
          end
        end
      end else if (canon && c == kill_ch) begin
        while (!ring_empty() && ring[step_down(wr_idx)] != tle_pkg::CH_LF) begin
          wr_idx = step_down(wr_idx);
          if (echo) add(tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 1'b0);
        end
      end else if (canon && (c == tle_pkg::CH_LF || c == tle_pkg::CH_CR)) begin
        store(tle_pkg::CH_LF);
        add(tle_pkg::KIND_WAKE, '0, 1'b0);
      end else if (!ring_full()) begin
        store(c);
        if (echo) add(tle_pkg::KIND_ECHO, c, 1'b0);
        if (!canon) add(tle_pkg::KIND_WAKE, '0, 1'b0);
      end
      if (pending.size() > n_prior) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [tle_pkg::KIND_W-1:0] kind,
                               logic [tle_pkg::BYTE_W-1:0] data,
                               logic eol, logic last);
      editor_word_t w;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, %s %0d byte %h eol %b last %b",
                 $realtime, "actual kind", kind, data, eol, last);
        return;
      end
      w = pending.pop_front();
      if (kind !== w.kind || data !== w.data || eol !== w.eol || last !== w.last) begin
        errors++;
        $display("%0t: result mismatch: expected kind %0d byte %h eol %b last %b,",
                 $realtime, w.kind, w.data, w.eol, w.last,
                 " actual kind %0d byte %h eol %b last %b", kind, data, eol, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   gaps_on = 1'b1;

  tle_in_if  in_bus ();
  tle_out_if out_bus ();
  tle_cfg_if cfg_bus ();

  line_editor_scoreboard sb = new();

  tty_canonical_line_editor dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The result sink stalls at random, with a chance of 29 in a hundred, while gaps are on.
  // Ready changes on the falling edge; words are taken at the rising edge.
  initial out_bus.ready = 1'b0;

  always @(negedge clk) begin
    out_bus.ready <= gaps_on ? ($urandom_range(0, 99) >= 29) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      sb.check_result(out_bus.kind, out_bus.out_byte, out_bus.end_of_line, out_bus.last);
    end
  end

  // Offer one input word, with a random gap first while gaps are on. The task
  // is entered and left at a falling edge and leaves valid high, so that the
  // next word can follow without a bubble; the caller lowers it.
  task automatic send_word(input logic act, input logic [tle_pkg::BYTE_W-1:0] b);
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.action  <= act;
    in_bus.in_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_input(act, b);
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected word, then let the block settle, so
  // that it is idle for a register write or for the end of the run.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all five registers back to back; only valid while the block is idle.
  task automatic write_config(input logic [tle_pkg::MODE_W-1:0] mode,
                              input logic [tle_pkg::BYTE_W-1:0] intr,
                              input logic [tle_pkg::BYTE_W-1:0] erase,
                              input logic [tle_pkg::BYTE_W-1:0] kill,
                              input logic fg);
    tle_pkg::tle_cfg_reg_e          idx [5];
    logic [tle_pkg::CFG_DATA_W-1:0] val [5];
    idx = '{tle_pkg::CFG_MODE, tle_pkg::CFG_INTR, tle_pkg::CFG_ERASE,
            tle_pkg::CFG_KILL, tle_pkg::CFG_FG};
    val = '{tle_pkg::CFG_DATA_W'(mode), intr, erase, kill, tle_pkg::CFG_DATA_W'(fg)};
    for (int i = 0; i < 5; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx[i];
      cfg_bus.data  <= val[i];
      do @(posedge clk); while (!cfg_bus.ready);
      sb.set_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Received bytes lean on text and the control bytes of the current setting,
  // with a share of fully random bytes so that every bit toggles.
  function automatic logic [tle_pkg::BYTE_W-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return tle_pkg::BYTE_W'($urandom_range(8'h20, 8'h7E));
    if (r < 60) return tle_pkg::BYTE_W'($urandom);
    case ($urandom_range(0, 5))
      0: return sb.intr_ch;
      1: return sb.erase_ch;
      2: return tle_pkg::CH_BS;
      3: return sb.kill_ch;
      4: return tle_pkg::CH_CR;
      default: return tle_pkg::CH_LF;
    endcase
  endfunction

  // One phase: a register setting, then a run of random words, then a drain.
  task automatic run_phase(input int p);
    logic [tle_pkg::MODE_W-1:0] mode;
    logic [tle_pkg::BYTE_W-1:0] intr;
    logic [tle_pkg::BYTE_W-1:0] erase;
    logic [tle_pkg::BYTE_W-1:0] kill;
    logic                       fg;
    int                         count;
    int                         read_pct;
    mode = tle_pkg::MODE_RESET;
    intr = tle_pkg::INTR_RESET;
    erase = tle_pkg::ERASE_RESET;
    kill = tle_pkg::KILL_RESET;
    fg = 1'b1;
    count = 20;
    read_pct = 25;
    gaps_on = 1'b1;
    case (p)
      1: begin
        // Fill the ring with text so that the full-ring drops are reached.
        count = 10;
      end
      2: begin
        // Raw mode with no signals and no echo; no idling on either side.
        mode = '0; intr = 8'h00; erase = 8'hFF; kill = 8'h00; fg = 1'b0;
        gaps_on = 1'b0;
      end
      3: begin
        // Silent canonical mode; erase and kill share one code, erase wins.
        mode = 3'd3; intr = 8'h80; erase = 8'h7F; kill = 8'h7F;
        gaps_on = 1'b0;
      end
      4: begin
        mode = 3'd5; intr = 8'hFF; erase = 8'h01; kill = 8'h02; fg = 1'b0;
      end
      5, 6: begin
        mode = tle_pkg::MODE_W'($urandom_range(0, 7));
        intr = tle_pkg::BYTE_W'($urandom);
        erase = tle_pkg::BYTE_W'($urandom);
        kill = tle_pkg::BYTE_W'($urandom);
        fg = 1'($urandom);
        if (p == 6) read_pct = 60;
      end
      default: ;
    endcase
    write_config(mode, intr, erase, kill, fg);
    if (p == 1) begin
      repeat (tle_pkg::RING_DEPTH + 2) begin
        send_word(ACT_RX, ($urandom_range(0, 99) < 10) ?
                  tle_pkg::CH_CR : tle_pkg::BYTE_W'($urandom_range(8'h20, 8'h7E)));
      end
      // The ring is full now: interrupt and newline are dropped but still
      // wake, and a plain byte vanishes without any result word.
      send_word(ACT_RX, intr);
      send_word(ACT_RX, tle_pkg::CH_LF);
      send_word(ACT_RX, 8'h78);
    end
    repeat (count) begin
      if ($urandom_range(0, 99) < read_pct) send_word(ACT_READ, tle_pkg::BYTE_W'($urandom));
      else send_word(ACT_RX, pick_byte());
    end
    wait_drained();
  endtask

  initial begin
    in_bus.valid   = 1'b0;
    in_bus.action  = ACT_RX;
    in_bus.in_byte = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = tle_pkg::CFG_MODE;
    cfg_bus.data   = '0;
    rst_n          = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part with the reset setting: echo, erase, kill, line end,
    // interrupt, the reads that return the stored bytes and reads of an empty ring.
    send_word(ACT_READ, 8'hFF);
    send_word(ACT_RX, 8'h61);
    send_word(ACT_RX, 8'hFF);
    send_word(ACT_RX, 8'h00);
    send_word(ACT_RX, tle_pkg::ERASE_RESET);
    send_word(ACT_RX, tle_pkg::KILL_RESET);
    send_word(ACT_RX, tle_pkg::ERASE_RESET);
    send_word(ACT_RX, tle_pkg::KILL_RESET);
    send_word(ACT_RX, 8'h68);
    send_word(ACT_RX, 8'h69);
    send_word(ACT_RX, tle_pkg::CH_CR);
    // Erase stops at a newline.
    send_word(ACT_RX, tle_pkg::CH_BS);
    send_word(ACT_RX, tle_pkg::INTR_RESET);
    send_word(ACT_RX, 8'h7E);
    send_word(ACT_RX, tle_pkg::CH_LF);
    repeat (6) send_word(ACT_READ, 8'h00);
    send_word(ACT_READ, 8'h00);
    wait_drained();

    for (int p = 0; p < 8; p++) run_phase(p);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake; a correct run needs far less time.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- tty_canonical_line_editor.f -----
+incdir+rtl/core
rtl/core/tle_pkg.sv
rtl/core/tle_if.sv
rtl/core/tle_dp.sv
rtl/core/tle_ctrl.sv
rtl/core/tty_canonical_line_editor.sv
sim/tty_canonical_line_editor_tb.sv
